// ===== design/pip_pkg.sv =====
// Shared types and constants for the point-in-polygon test block.
// Used by pip_div and point_in_polygon_test; depends on nothing else.
package pip_pkg;

    // Vertex table size and derived widths
    localparam int MAX_VERTICES = 64;
    localparam int IDX_W        = $clog2(MAX_VERTICES);
    localparam int CNT_W        = 7;
    localparam int COORD_W      = 16;
    localparam int DIFF_W       = COORD_W + 1;
    localparam int PROD_W       = 2 * DIFF_W;

    // A polygon needs more vertices than this to be tested
    localparam int FEW_LIMIT = 2;

    // Action codes of an input word
    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_TEST  = 1'b1;

    typedef struct packed {
        logic                      action;
        logic [5:0]                vertex_index;
        logic signed [COORD_W-1:0] coord_x;
        logic signed [COORD_W-1:0] coord_y;
    } in_word_t;

    typedef struct packed {
        logic inside_res;
        logic too_few_vertices;
    } out_word_t;

    // Divider status seen by the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

// ===== design/pip_div.sv =====
// Serial restoring divider for unsigned magnitudes, one quotient bit per cycle.
// Depends on pip_pkg for operand widths and the status struct.
module pip_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [pip_pkg::PROD_W-1:0]  dividend,
    input  logic [pip_pkg::DIFF_W-1:0]  divisor,
    output logic [pip_pkg::PROD_W-1:0]  quotient,
    output pip_pkg::div_stat_t          stat
);
    import pip_pkg::*;

    localparam int STEP_W = $clog2(PROD_W);

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] step_reg;
    logic [PROD_W-1:0] quot_reg;
    logic [DIFF_W-1:0] rem_reg;
    logic [DIFF_W-1:0] den_reg;
    logic [DIFF_W:0]   trial;
    logic              fits;

    // Shift the next dividend bit into the partial remainder and try the subtraction
    assign trial = {rem_reg, quot_reg[PROD_W-1]};
    assign fits  = trial >= {1'b0, den_reg};

    // Control: count the steps and pulse done after the last one
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(PROD_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: load operands, then advance one quotient bit a cycle
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quot_reg <= dividend;
            den_reg  <= divisor;
            rem_reg  <= '0;
        end
        else if (busy_reg)
        begin
            if (fits)
            begin
                rem_reg  <= DIFF_W'(trial - {1'b0, den_reg});
                quot_reg <= {quot_reg[PROD_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= trial[DIFF_W-1:0];
                quot_reg <= {quot_reg[PROD_W-2:0], 1'b0};
            end
        end
    end

    assign quotient  = quot_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

// ===== design/point_in_polygon_test.sv =====
// Even-odd ray-casting point-in-polygon test over a vertex table held in RAM.
// A vertex write, or a test with two or fewer vertices, answers in the cycle after start.
// A test reads the last vertex, then walks the edges in turn; an edge that misses the ray
// is skipped, while one that straddles it is multiplied, divided serially and compared.
// busy stays high until the strobe; the receiver cannot stall the result.
// Reset clears the vertex count and control; the vertex table is undefined until written.
module point_in_polygon_test (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  pip_pkg::in_word_t           in_word,
    input  logic                        cfg_we,
    input  logic [pip_pkg::CNT_W-1:0]   cfg_data,
    output logic                        done,
    output pip_pkg::out_word_t          res_word
);
    import pip_pkg::*;

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_LOADJ = 8'b0000_0010,
        ST_EDGE  = 8'b0000_0100,
        ST_MUL   = 8'b0000_1000,
        ST_DIVGO = 8'b0001_0000,
        ST_DIV   = 8'b0010_0000,
        ST_CMP   = 8'b0100_0000,
        ST_NEXT  = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    logic [CNT_W-1:0]         count_reg;
    logic [CNT_W-1:0]         n_eff;
    logic                     accept;
    logic                     few;

    logic [2*COORD_W-1:0]     mem [0:MAX_VERTICES-1];
    logic [2*COORD_W-1:0]     rd_data_reg;
    logic [IDX_W-1:0]         rd_addr;
    logic                     mem_we;

    logic [IDX_W-1:0]         last_reg;
    logic [IDX_W-1:0]         i_reg;
    logic signed [COORD_W-1:0] px_reg, py_reg;
    logic signed [COORD_W-1:0] xj_reg, yj_reg, xi_reg;
    logic signed [DIFF_W-1:0] dx_reg, dyp_reg, dy_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic                     neg_reg;
    logic                     inside_reg;
    logic                     done_reg;
    out_word_t                res_reg;

    logic signed [COORD_W-1:0] xi, yi;
    logic                     straddle;
    logic                     div_start;
    logic [PROD_W-1:0]        prod_mag;
    logic [DIFF_W-1:0]        dy_mag;
    logic [PROD_W-1:0]        quot;
    div_stat_t                div_stat;
    logic signed [PROD_W:0]   q_signed;
    logic signed [PROD_W+1:0] edge_x;
    logic                     crosses;

    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && !busy;

    // Clamp the vertex count to the table size
    assign n_eff = (count_reg > CNT_W'(MAX_VERTICES)) ? CNT_W'(MAX_VERTICES) : count_reg;
    assign few   = (n_eff <= CNT_W'(FEW_LIMIT));

    // Vertex count register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else if (cfg_we)
            count_reg <= cfg_data;
    end

    // Vertex RAM: one write port, one registered read port
    assign mem_we = accept && (in_word.action == ACT_WRITE)
                    && (32'(in_word.vertex_index) < MAX_VERTICES);

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[IDX_W'(in_word.vertex_index)] <= {in_word.coord_x, in_word.coord_y};
        rd_data_reg <= mem[rd_addr];
    end

    assign xi = rd_data_reg[2*COORD_W-1:COORD_W];
    assign yi = rd_data_reg[COORD_W-1:0];
    assign straddle = (yi >= py_reg) != (yj_reg >= py_reg);

    // Read address per state: last vertex first, then vertex 0, then each next one
    always_comb
    begin
        rd_addr = i_reg + IDX_W'(1);
        unique case (state_reg)
            ST_IDLE:  rd_addr = IDX_W'(n_eff - CNT_W'(1));
            ST_LOADJ: rd_addr = '0;
            default:  rd_addr = i_reg + IDX_W'(1);
        endcase
    end

    // Magnitudes and divider
    assign prod_mag  = prod_reg[PROD_W-1] ? PROD_W'(-prod_reg) : PROD_W'(prod_reg);
    assign dy_mag    = dy_reg[DIFF_W-1] ? DIFF_W'(-dy_reg) : DIFF_W'(dy_reg);
    assign div_start = (state_reg == ST_DIVGO);

    pip_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (prod_mag),
        .divisor  (dy_mag),
        .quotient (quot),
        .stat     (div_stat)
    );

    // Restore the sign of the quotient, add xi and compare with px
    assign q_signed = neg_reg ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
    assign edge_x   = (PROD_W+2)'(q_signed) + (PROD_W+2)'(xi_reg);
    assign crosses  = (PROD_W+2)'(px_reg) < edge_x;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (accept && (in_word.action == ACT_TEST) && !few)
                    state_next = ST_LOADJ;
            ST_LOADJ: state_next = ST_EDGE;
            ST_EDGE:  state_next = straddle ? ST_MUL : ST_NEXT;
            ST_MUL:   state_next = ST_DIVGO;
            ST_DIVGO: state_next = ST_DIV;
            ST_DIV:
                if (div_stat.done)
                    state_next = ST_CMP;
            ST_CMP:   state_next = ST_NEXT;
            ST_NEXT:  state_next = (i_reg == last_reg) ? ST_IDLE : ST_EDGE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // Control registers: state, edge index, parity and result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            i_reg      <= '0;
            inside_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                    if (accept)
                    begin
                        i_reg      <= '0;
                        inside_reg <= 1'b0;
                        if ((in_word.action == ACT_WRITE) || few)
                            done_reg <= 1'b1;
                    end
                ST_CMP:
                    if (crosses)
                        inside_reg <= !inside_reg;
                ST_NEXT:
                    if (i_reg == last_reg)
                        done_reg <= 1'b1;
                    else
                        i_reg <= i_reg + IDX_W'(1);
                default:
                    begin
                    end
            endcase
        end
    end

    // Datapath registers: query point, last index, previous vertex, differences, product, sign, result
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
                if (accept)
                begin
                    px_reg   <= in_word.coord_x;
                    py_reg   <= in_word.coord_y;
                    last_reg <= IDX_W'(n_eff - CNT_W'(1));
                    res_reg.inside_res       <= 1'b0;
                    res_reg.too_few_vertices <= (in_word.action == ACT_TEST) && few;
                end
            ST_LOADJ:
                begin
                    xj_reg <= xi;
                    yj_reg <= yi;
                end
            ST_EDGE:
                begin
                    dx_reg  <= DIFF_W'(xj_reg) - DIFF_W'(xi);
                    dyp_reg <= DIFF_W'(py_reg) - DIFF_W'(yi);
                    dy_reg  <= DIFF_W'(yj_reg) - DIFF_W'(yi);
                    xi_reg  <= xi;
                    xj_reg  <= xi;
                    yj_reg  <= yi;
                end
            ST_MUL:
                prod_reg <= dx_reg * dyp_reg;
            ST_DIVGO:
                neg_reg <= prod_reg[PROD_W-1] ^ dy_reg[DIFF_W-1];
            ST_NEXT:
                if (i_reg == last_reg)
                begin
                    res_reg.inside_res       <= inside_reg;
                    res_reg.too_few_vertices <= 1'b0;
                end
            default:
                begin
                end
        endcase
    end

    assign done     = done_reg;
    assign res_word = res_reg;

    // A strobe only follows an accepted word or a running test
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($past(start && !busy) || $past(busy)))
        else $error("result strobe without a word in flight");

    // The strobe never overlaps busy, so the next word can start at once
    assert property (@(posedge clk) disable iff (!rst_n)
        !(done && busy))
        else $error("busy still high with the result strobe");

    // A vertex write answers next cycle with a cleared result
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (in_word.action == ACT_WRITE)) |=> (done && (res_word == '0)))
        else $error("vertex write answered wrongly");

    // A degenerate polygon never reports inside
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && res_word.too_few_vertices) |-> !res_word.inside_res)
        else $error("inside reported with too few vertices");

    // The divider only runs while the sequencer waits for it
    assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.busy |-> (state_reg == ST_DIV))
        else $error("divider running outside the divide state");

endmodule
